/* src/rcr_pkg.sv */
// Package: shared types and constants for the register change recorder.
`timescale 1ns / 1ps
package rcr_pkg;
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [15:0] IGNORED_RESET = 16'd833;
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_UPDATE = 2'd1;
   localparam logic [1:0] CMD_STOP = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam logic ADDR_IGNORED = 1'b0;

   typedef struct packed {
      logic [1:0] cmd;
      logic [15:0] reg_index;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic kind;
      logic [15:0] entry_index;
      logic signed [15:0] first_value;
      logic signed [15:0] latest_value;
      logic signed [15:0] difference;
      logic signed [15:0] lowest_value;
      logic signed [15:0] highest_value;
      logic [15:0] change_total;
      logic last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_UPD_READ, ST_UPD_WRITE, ST_STOP_MAX_SCAN,
      ST_STOP_READ, ST_STOP_CHECK, ST_STOP_EMIT, ST_STOP_LOOK, ST_OUT
   } state_type;

   typedef struct packed {
      logic clear_step;    // clear used bit at scan_idx, advance scan
      logic load_req;      // capture request
      logic mem_read_req;  // read entry at request index
      logic upd_write;     // perform update write
      logic scan_reset;    // scan_idx = 0
      logic scan_step;     // advance scan
      logic mem_read_scan; // read entry at scan index
      logic max_track;     // fold entry into max search
      logic max_reset;     // clear max register
      logic emit_summary;  // load summary into output register
      logic target_top;    // target = all ones for the first pass
      logic target_next;   // target = found next lower count
      logic emit_notice;   // load notice into output register
      logic mark_last;     // set last on held output
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic req_ok;        // update may touch the table
      logic entry_used;
      logic entry_changed; // new value differs from latest
      logic match;         // scanned entry matches target count
      logic has_next;      // lower count exists
   } status_type;
endpackage

/* src/rcr_datapath.sv */
// Datapath: entry table memory, scan counter, count search and result register.
`timescale 1ns / 1ps
module rcr_datapath (
   input  logic clock,
   input  logic reset,
   input  rcr_pkg::cmd_type cmd,
   output rcr_pkg::status_type status,
   input  rcr_pkg::req_type req_data,
   input  logic [15:0] ignored_reg,
   input  logic recording,
   output rcr_pkg::rsp_type rsp_data
);
   import rcr_pkg::*;

   logic [TABLE_DEPTH-1:0] used_ff;
   logic [79:0] mem [TABLE_DEPTH];
   logic [79:0] rd_ff;
   req_type req_ff;
   logic [CNT_W-1:0] scan_ff;
   logic [15:0] target_ff, next_ff;
   logic has_next_ff;
   rsp_type out_ff;
   logic [IDX_W-1:0] ridx;
   logic [IDX_W-1:0] sidx;
   logic [15:0] f_first, f_latest, f_low, f_high, f_cnt, new_cnt, new_low, new_high;
   logic [79:0] wdata;

   assign ridx = req_ff.reg_index[IDX_W-1:0];
   assign sidx = scan_ff[IDX_W-1:0];
   assign {f_first, f_latest, f_low, f_high, f_cnt} = rd_ff;
   assign new_cnt = (f_cnt == 16'hFFFF) ? f_cnt : f_cnt + 16'd1;
   assign new_low = ($signed(req_ff.value) < $signed(f_low)) ? req_ff.value : f_low;
   assign new_high = ($signed(req_ff.value) > $signed(f_high)) ? req_ff.value : f_high;

   always_comb begin
      if (!used_ff[ridx]) begin
         wdata = {req_ff.value, req_ff.value, req_ff.value, req_ff.value, 16'd0};
      end else begin
         wdata = {f_first, req_ff.value, new_low, new_high, new_cnt};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      if (cmd.mem_read_req) rd_ff <= mem[ridx];
      else if (cmd.mem_read_scan) rd_ff <= mem[sidx];
      if (cmd.upd_write && (!used_ff[ridx] || status.entry_changed)) mem[ridx] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         scan_ff <= '0;
         target_ff <= '0;
         next_ff <= '0;
         has_next_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) used_ff[sidx] <= 1'b0;
         if (cmd.upd_write) used_ff[ridx] <= 1'b1;
         if (cmd.scan_reset) scan_ff <= '0;
         else if (cmd.scan_step || cmd.clear_step) scan_ff <= scan_ff + 1'b1;
         if (cmd.max_reset) begin
            next_ff <= '0;
            has_next_ff <= 1'b0;
         end else if (cmd.max_track && used_ff[sidx]) begin
            // track largest nonzero count strictly below target (target is all ones on the first pass)
            if (f_cnt != 16'd0 && f_cnt < target_ff && f_cnt > next_ff) begin
               next_ff <= f_cnt;
               has_next_ff <= 1'b1;
            end
         end
         if (cmd.target_top) target_ff <= 16'hFFFF;
         else if (cmd.target_next) target_ff <= next_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_notice) begin
         out_ff <= {1'b0, req_ff.reg_index, 16'd0, req_ff.value,
                    16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
      end else if (cmd.emit_summary) begin
         out_ff.kind <= 1'b1;
         out_ff.entry_index <= 16'(scan_ff);
         out_ff.first_value <= f_first;
         out_ff.latest_value <= f_latest;
         out_ff.difference <= f_latest - f_first;
         out_ff.lowest_value <= f_low;
         out_ff.highest_value <= f_high;
         out_ff.change_total <= f_cnt;
         out_ff.last <= 1'b0;
      end else if (cmd.mark_last) begin
         out_ff.last <= 1'b1;
      end
   end

   assign rsp_data = out_ff;
   assign status.scan_done = (scan_ff == CNT_W'(TABLE_DEPTH - 1));
   assign status.req_ok = recording && (req_ff.reg_index < 16'(TABLE_DEPTH))
                          && (req_ff.reg_index != ignored_reg);
   assign status.entry_used = used_ff[ridx];
   assign status.entry_changed = (req_ff.value != f_latest);
   assign status.match = used_ff[sidx] && (f_cnt == target_ff) && (f_cnt != 16'd0);
   assign status.has_next = has_next_ff;
endmodule

/* src/rcr_controller.sv */
// Controller: sequences start, update and stop transactions.
`timescale 1ns / 1ps
module rcr_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_cmd,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rcr_pkg::cmd_type cmd,
   input  rcr_pkg::status_type status,
   output logic recording
);
   import rcr_pkg::*;

   state_type state_ff, state_in;
   logic rec_ff, rec_in;
   logic vld_ff, vld_in;
   logic pend_ff, pend_in;  // summary result waits for its successor
   logic take;

   assign req_stall = (state_ff != ST_IDLE) || vld_ff;
   assign take = req_valid && !req_stall;
   assign rsp_valid = vld_ff;
   assign recording = rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rec_ff <= 1'b0;
         vld_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rec_ff <= rec_in;
         vld_ff <= vld_in;
         pend_ff <= pend_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               case (req_cmd)
                  CMD_START: state_in = ST_CLEAR;
                  CMD_UPDATE: state_in = ST_UPD_READ;
                  CMD_STOP: state_in = ST_STOP_MAX_SCAN;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: if (status.scan_done) state_in = ST_IDLE;
         ST_UPD_READ: state_in = status.req_ok ? ST_UPD_WRITE : ST_IDLE;
         ST_UPD_WRITE: state_in = ST_IDLE;
         ST_STOP_MAX_SCAN: state_in = ST_STOP_READ;
         ST_STOP_READ: state_in = ST_STOP_CHECK;
         ST_STOP_CHECK: begin
            if (status.match) state_in = ST_STOP_EMIT;
            else if (status.scan_done) state_in = ST_STOP_LOOK;
            else state_in = ST_STOP_READ;
         end
         ST_STOP_EMIT: begin
            if (pend_ff || (vld_ff && rsp_stall)) state_in = ST_STOP_EMIT;
            else if (status.scan_done) state_in = ST_STOP_LOOK;
            else state_in = ST_STOP_READ;
         end
         ST_STOP_LOOK: state_in = status.has_next ? ST_STOP_READ : ST_OUT;
         ST_OUT: if (!vld_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      rec_in = rec_ff;
      vld_in = vld_ff && rsp_stall;
      pend_in = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.load_req = 1'b1;
               cmd.scan_reset = 1'b1;
               cmd.max_reset = 1'b1;
               if (req_cmd == CMD_START) rec_in = 1'b1;
               if (req_cmd == CMD_STOP) rec_in = 1'b0;
            end
         end
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_UPD_READ: cmd.mem_read_req = 1'b1;
         ST_UPD_WRITE: begin
            cmd.upd_write = 1'b1;
            if (status.entry_used && status.entry_changed) begin
               cmd.emit_notice = 1'b1;
               vld_in = 1'b1;
            end
         end
         ST_STOP_MAX_SCAN: begin
            // first pass finds top count: target starts at all ones
            cmd.max_reset = 1'b1;
            cmd.target_top = 1'b1;
         end
         ST_STOP_READ: cmd.mem_read_scan = 1'b1;
         ST_STOP_CHECK: begin
            cmd.max_track = 1'b1;
            if (!status.match && !status.scan_done) cmd.scan_step = 1'b1;
         end
         ST_STOP_EMIT: begin
            if (pend_ff) begin
               // a later summary exists, so the held one is not the final one
               pend_in = 1'b0;
               vld_in = 1'b1;
            end else if (!(vld_ff && rsp_stall)) begin
               // output register free: load this summary and hold it back
               cmd.emit_summary = 1'b1;
               pend_in = 1'b1;
               if (!status.scan_done) cmd.scan_step = 1'b1;
            end
         end
         ST_STOP_LOOK: begin
            cmd.target_next = 1'b1;
            cmd.max_reset = 1'b1;
            cmd.scan_reset = 1'b1;
         end
         ST_OUT: begin
            if (pend_ff) begin
               cmd.mark_last = 1'b1;
               pend_in = 1'b0;
               vld_in = 1'b1;
            end
         end
         default: ;
      endcase
   end
endmodule

/* src/register_change_recorder.sv */
// Top level: register change recorder with APB-style register port.
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// req_    | in        | req_valid / req_stall  | rcr_pkg::req_type
// rsp_    | out       | rsp_valid / rsp_stall  | rcr_pkg::rsp_type
// csr_    | in        | APB write/read         | ignored_register at 0x0
// Start: after the accept step, one used bit is cleared per cycle across all TABLE_DEPTH entries.
// Update: accept, read entry, then write entry; a change notice then blocks new
// requests until it is taken.
// Stop: one table pass for the all-ones target, then one per lower distinct nonzero
// change count, each entry read then checked, plus summary steps; stalls add to each.
// Reset is synchronous, active high; table contents need no clearing.
// A held result blocks new request transactions until taken.
module register_change_recorder (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  rcr_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rcr_pkg::rsp_type rsp_data,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import rcr_pkg::*;

   logic [15:0] ignored_ff;
   cmd_type cmd;
   status_type status;
   logic recording;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         ignored_ff <= IGNORED_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[1:0] == {ADDR_IGNORED, 1'b0}) begin
         ignored_ff <= csr_pwdata[15:0];
      end
   end
   assign csr_prdata = (csr_paddr == {ADDR_IGNORED, 1'b0}) ? {16'd0, ignored_ff} : 32'd0;

   rcr_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_cmd(req_data.cmd),
      .rsp_valid, .rsp_stall, .cmd, .status, .recording
   );

   rcr_datapath u_dp (
      .clock, .reset, .cmd, .status, .req_data, .ignored_reg(ignored_ff),
      .recording, .rsp_data
   );
endmodule
